// ===== rtl/lsan_pkg.sv =====
// Shared types and constants for the Lamport slot admission node.
// Holds table sizes, field widths, message kinds and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package lsan_pkg;

   // table sizes and clock width
   localparam int NUM_PEERS    = 8;
   localparam int NUM_PARTNERS = 16;
   localparam int CLOCK_WIDTH  = 32;

   // fixed field widths of the item and result beats
   localparam int KIND_W      = 3;
   localparam int PEER_ID_W   = 3;
   localparam int PART_FLD_W  = 4;
   localparam int MSG_CLOCK_W = 32;
   localparam int SLOT_W      = 4;
   localparam int OWN_ID_W    = 3;
   localparam int TOTAL_W     = 4;
   localparam int OCC_OUT_W   = 7;
   localparam int OCC_OUT_MAX = 127;

   // derived index and accumulator widths
   localparam int PEER_IDX_W = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
   localparam int PART_IDX_W = (NUM_PARTNERS > 1) ? $clog2(NUM_PARTNERS) : 1;
   localparam int SCAN_LEN   = (NUM_PEERS > NUM_PARTNERS) ? NUM_PEERS : NUM_PARTNERS;
   localparam int SCAN_W     = $clog2(SCAN_LEN);
   localparam int OCC_W      = $clog2(NUM_PEERS * ((1 << SLOT_W) - 1) + 1);
   localparam int OCC_SUM_W  = OCC_W + 1;

   // offer priorities
   localparam int              PRIO_W   = 8;
   localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

   localparam logic [TOTAL_W-1:0] RESET_TOTAL_SLOTS = 4'd10;

   typedef enum logic [KIND_W-1:0] {
      KIND_PEER_REQ     = 3'd0,
      KIND_PEER_REL     = 3'd1,
      KIND_OFFER        = 3'd2,
      KIND_PARTNER_ACK  = 3'd3,
      KIND_PEER_ACK     = 3'd4,
      KIND_OWN_REQ      = 3'd5,
      KIND_OWN_REL      = 3'd6,
      KIND_ASK_PARTNER  = 3'd7
   } kind_type;

   typedef enum logic [0:0] {
      REG_TOTAL_SLOTS = 1'b0,
      REG_OWN_ID      = 1'b1
   } csr_reg_type;

   typedef struct packed {
      kind_type                kind;
      logic [PEER_ID_W-1:0]    peer_id;
      logic [PART_FLD_W-1:0]   partner_index;
      logic [MSG_CLOCK_W-1:0]  msg_clock;
      logic [SLOT_W-1:0]       slot_count;
   } item_type;

   typedef struct packed {
      logic                    active;
      logic                    acked;
      logic [CLOCK_WIDTH-1:0]  stamp;
      logic [SLOT_W-1:0]       slots;
   } peer_entry_type;

   typedef struct packed {
      logic                    pending;
      logic [PRIO_W-1:0]       prio;
   } part_entry_type;

   typedef struct packed {
      logic [CLOCK_WIDTH-1:0]  lamport;
      logic                    ack;
      logic                    pair_valid;
      logic [PART_IDX_W-1:0]   pair_index;
      logic                    own_active;
      logic [CLOCK_WIDTH-1:0]  own_stamp;
      logic [SLOT_W-1:0]       own_slots;
   } node_view_type;

   typedef struct packed {
      logic                    best_valid;
      logic [PART_IDX_W-1:0]   best_index;
      logic                    all_acks_in;
      logic                    admit;
      logic [OCC_OUT_W-1:0]    occupied;
   } scan_result_type;

endpackage

// ===== rtl/lsan_state.sv =====
// Node state of the Lamport slot admission node: clock, peer and partner tables,
// pairing and own request, updated once per accepted item. Uses lsan_pkg.
`timescale 1ns / 1ps

module lsan_state (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               apply,
   input  lsan_pkg::item_type                 item,
   input  logic [lsan_pkg::OWN_ID_W-1:0]      own_id,
   input  logic [lsan_pkg::PEER_IDX_W-1:0]    peer_sel,
   input  logic [lsan_pkg::PART_IDX_W-1:0]    part_sel,
   output lsan_pkg::peer_entry_type           peer_rd,
   output lsan_pkg::part_entry_type           part_rd,
   output lsan_pkg::node_view_type            node
);
   import lsan_pkg::*;

   logic [CLOCK_WIDTH-1:0] lamport_ff, lamport_in;
   logic                   peer_active_ff [NUM_PEERS];
   logic                   peer_active_in [NUM_PEERS];
   logic                   peer_acked_ff  [NUM_PEERS];
   logic                   peer_acked_in  [NUM_PEERS];
   logic [CLOCK_WIDTH-1:0] peer_stamp_ff  [NUM_PEERS];
   logic [CLOCK_WIDTH-1:0] peer_stamp_in  [NUM_PEERS];
   logic [SLOT_W-1:0]      peer_slots_ff  [NUM_PEERS];
   logic [SLOT_W-1:0]      peer_slots_in  [NUM_PEERS];
   logic [NUM_PARTNERS-1:0] offer_pending_ff, offer_pending_in;
   logic [PRIO_W-1:0]      offer_prio_ff [NUM_PARTNERS];
   logic [PRIO_W-1:0]      offer_prio_in [NUM_PARTNERS];
   logic                   pair_valid_ff, pair_valid_in;
   logic [PART_IDX_W-1:0]  pair_index_ff, pair_index_in;
   logic                   own_active_ff, own_active_in;
   logic [CLOCK_WIDTH-1:0] own_stamp_ff, own_stamp_in;
   logic [SLOT_W-1:0]      own_slots_ff, own_slots_in;
   logic                   ack_ff, ack_in;

   logic [CLOCK_WIDTH-1:0] msg_clk;
   logic [CLOCK_WIDTH-1:0] recv_base;
   logic [CLOCK_WIDTH-1:0] send_clk;
   logic [CLOCK_WIDTH-1:0] clk_base;
   logic [1:0]             clk_step;
   logic                   peer_ok;
   logic                   part_ok;
   logic [PEER_IDX_W-1:0]  pid;
   logic [PART_IDX_W-1:0]  pix;

   // decode the beat and work out the next state
   always_comb begin
      msg_clk   = CLOCK_WIDTH'(item.msg_clock);
      recv_base = (msg_clk > lamport_ff) ? msg_clk : lamport_ff;
      send_clk  = lamport_ff + CLOCK_WIDTH'(1);
      peer_ok   = (32'(item.peer_id) < NUM_PEERS) && (item.peer_id != own_id);
      part_ok   = 32'(item.partner_index) < NUM_PARTNERS;
      pid       = PEER_IDX_W'(item.peer_id);
      pix       = PART_IDX_W'(item.partner_index);

      peer_active_in   = peer_active_ff;
      peer_acked_in    = peer_acked_ff;
      peer_stamp_in    = peer_stamp_ff;
      peer_slots_in    = peer_slots_ff;
      offer_pending_in = offer_pending_ff;
      offer_prio_in    = offer_prio_ff;
      pair_valid_in    = pair_valid_ff;
      pair_index_in    = pair_index_ff;
      own_active_in    = own_active_ff;
      own_stamp_in     = own_stamp_ff;
      own_slots_in     = own_slots_ff;
      ack_in           = ack_ff;
      clk_base         = lamport_ff;
      clk_step         = 2'd0;

      if (apply) begin
         ack_in = 1'b0;
         unique case (item.kind)
            KIND_PEER_REQ: begin
               clk_base = recv_base;
               clk_step = peer_ok ? 2'd2 : 2'd1;
               if (part_ok) begin
                  offer_pending_in[pix] = 1'b0;
               end
               if (peer_ok) begin
                  peer_active_in[pid] = 1'b1;
                  peer_stamp_in[pid]  = msg_clk;
                  peer_slots_in[pid]  = item.slot_count;
                  ack_in              = 1'b1;
               end
            end
            KIND_PEER_REL: begin
               clk_base = recv_base;
               clk_step = 2'd1;
               if (peer_ok) begin
                  peer_active_in[pid] = 1'b0;
               end
            end
            KIND_OFFER: begin
               clk_base = recv_base;
               clk_step = 2'd1;
               if (part_ok) begin
                  offer_pending_in[pix] = 1'b1;
               end
            end
            KIND_PARTNER_ACK: begin
               clk_base = recv_base;
               clk_step = 2'd1;
               if (part_ok) begin
                  offer_pending_in[pix] = 1'b0;
                  // age every other offer, saturating
                  for (int g = 0; g < NUM_PARTNERS; g++) begin
                     if (PART_IDX_W'(g) == pix) begin
                        offer_prio_in[g] = '0;
                     end else if (offer_prio_ff[g] != PRIO_MAX) begin
                        offer_prio_in[g] = offer_prio_ff[g] + PRIO_W'(1);
                     end
                  end
                  pair_valid_in = 1'b1;
                  pair_index_in = pix;
               end
            end
            KIND_PEER_ACK: begin
               clk_base = recv_base;
               clk_step = 2'd1;
               if (peer_ok) begin
                  peer_acked_in[pid] = 1'b1;
               end
            end
            KIND_OWN_REQ: begin
               clk_step      = 2'd1;
               own_stamp_in  = send_clk;
               own_slots_in  = item.slot_count;
               own_active_in = 1'b1;
               for (int i = 0; i < NUM_PEERS; i++) begin
                  peer_acked_in[i] = 1'b0;
               end
            end
            KIND_OWN_REL: begin
               clk_step      = 2'd1;
               own_active_in = 1'b0;
               pair_valid_in = 1'b0;
            end
            KIND_ASK_PARTNER: begin
               clk_step = (|offer_pending_ff) ? 2'd1 : 2'd0;
            end
            default: begin
               clk_step = 2'd0;
            end
         endcase
      end

      lamport_in = clk_base + CLOCK_WIDTH'(clk_step);
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         lamport_ff       <= '0;
         offer_pending_ff <= '0;
         pair_valid_ff    <= 1'b0;
         pair_index_ff    <= '0;
         own_active_ff    <= 1'b0;
         own_stamp_ff     <= '0;
         own_slots_ff     <= '0;
         ack_ff           <= 1'b0;
         for (int i = 0; i < NUM_PEERS; i++) begin
            peer_active_ff[i] <= 1'b0;
            peer_acked_ff[i]  <= 1'b0;
         end
         for (int g = 0; g < NUM_PARTNERS; g++) begin
            offer_prio_ff[g] <= '0;
         end
      end else begin
         lamport_ff       <= lamport_in;
         offer_pending_ff <= offer_pending_in;
         pair_valid_ff    <= pair_valid_in;
         pair_index_ff    <= pair_index_in;
         own_active_ff    <= own_active_in;
         own_stamp_ff     <= own_stamp_in;
         own_slots_ff     <= own_slots_in;
         ack_ff           <= ack_in;
         peer_active_ff   <= peer_active_in;
         peer_acked_ff    <= peer_acked_in;
         offer_prio_ff    <= offer_prio_in;
      end
   end

   // peer request payload, only read for active peers
   always_ff @(posedge clock) begin
      peer_stamp_ff <= peer_stamp_in;
      peer_slots_ff <= peer_slots_in;
   end

   // table read ports for the scan
   always_comb begin
      peer_rd.active  = peer_active_ff[peer_sel];
      peer_rd.acked   = peer_acked_ff[peer_sel];
      peer_rd.stamp   = peer_stamp_ff[peer_sel];
      peer_rd.slots   = peer_slots_ff[peer_sel];
      part_rd.pending = offer_pending_ff[part_sel];
      part_rd.prio    = offer_prio_ff[part_sel];
   end

   assign node.lamport    = lamport_ff;
   assign node.ack        = ack_ff;
   assign node.pair_valid = pair_valid_ff;
   assign node.pair_index = pair_index_ff;
   assign node.own_active = own_active_ff;
   assign node.own_stamp  = own_stamp_ff;
   assign node.own_slots  = own_slots_ff;

endmodule

// ===== rtl/lsan_scan.sv =====
// Iterative table scan of the Lamport slot admission node: one stamp comparator and
// one accumulator step per cycle over the peer and partner tables. Uses lsan_pkg.
`timescale 1ns / 1ps

module lsan_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lsan_pkg::OWN_ID_W-1:0]      own_id,
   input  logic [lsan_pkg::TOTAL_W-1:0]       total_slots,
   input  lsan_pkg::node_view_type            node,
   input  lsan_pkg::peer_entry_type           peer_rd,
   input  lsan_pkg::part_entry_type           part_rd,
   output logic [lsan_pkg::PEER_IDX_W-1:0]    peer_sel,
   output logic [lsan_pkg::PART_IDX_W-1:0]    part_sel,
   output logic                               done,
   output lsan_pkg::scan_result_type          result
);
   import lsan_pkg::*;

   logic                  busy_ff, busy_in;
   logic [SCAN_W-1:0]     cnt_ff, cnt_in;
   logic                  acks_ff, acks_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic                  bvalid_ff, bvalid_in;
   logic [PART_IDX_W-1:0] bidx_ff, bidx_in;
   logic [PRIO_W-1:0]     bprio_ff, bprio_in;

   logic                  peer_here;
   logic                  part_here;
   logic                  not_self;
   logic                  older;
   logic                  last;
   logic                  acks_eff;
   logic [OCC_W-1:0]      occ_eff;

   // one step of the scan
   always_comb begin
      peer_here = 32'(cnt_ff) < NUM_PEERS;
      part_here = 32'(cnt_ff) < NUM_PARTNERS;
      peer_sel  = peer_here ? PEER_IDX_W'(cnt_ff) : '0;
      part_sel  = part_here ? PART_IDX_W'(cnt_ff) : '0;
      not_self  = 32'(cnt_ff) != 32'(own_id);
      // older: lower stamp, or equal stamp with lower id
      older     = (peer_rd.stamp < node.own_stamp) ||
                  ((peer_rd.stamp == node.own_stamp) && (32'(cnt_ff) < 32'(own_id)));
      last      = cnt_ff == SCAN_W'(SCAN_LEN - 1);
      done      = busy_ff && last;

      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      acks_in   = acks_ff;
      occ_in    = occ_ff;
      bvalid_in = bvalid_ff;
      bidx_in   = bidx_ff;
      bprio_in  = bprio_ff;

      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acks_in   = 1'b1;
         occ_in    = '0;
         bvalid_in = 1'b0;
         bidx_in   = '0;
         bprio_in  = '0;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + SCAN_W'(1);
         busy_in = !last;
         if (peer_here && not_self) begin
            if (!peer_rd.acked) begin
               acks_in = 1'b0;
            end
            if (peer_rd.active && older) begin
               occ_in = occ_ff + OCC_W'(peer_rd.slots);
            end
         end
         // strictly higher priority wins, so ties keep the lower index
         if (part_here && part_rd.pending && (!bvalid_ff || (part_rd.prio > bprio_ff))) begin
            bvalid_in = 1'b1;
            bidx_in   = part_sel;
            bprio_in  = part_rd.prio;
         end
      end
   end

   // advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // accumulators, cleared on start
   always_ff @(posedge clock) begin
      acks_ff   <= acks_in;
      occ_ff    <= occ_in;
      bvalid_ff <= bvalid_in;
      bidx_ff   <= bidx_in;
      bprio_ff  <= bprio_in;
   end

   // final admission decision
   always_comb begin
      acks_eff           = node.own_active && acks_ff;
      occ_eff            = node.own_active ? occ_ff : '0;
      result.best_valid  = bvalid_ff;
      result.best_index  = bidx_ff;
      result.all_acks_in = acks_eff;
      result.admit       = acks_eff &&
                           ((OCC_SUM_W'(occ_eff) + OCC_SUM_W'(node.own_slots)) <=
                            OCC_SUM_W'(total_slots));
      result.occupied    = (32'(occ_eff) > OCC_OUT_MAX) ? OCC_OUT_W'(OCC_OUT_MAX)
                                                        : OCC_OUT_W'(occ_eff);
   end

endmodule

// ===== rtl/lamport_slot_admission_node_top.sv =====
// Top level of the Lamport slot admission node: register port, sequencer and result register.
// Instantiates lsan_state and lsan_scan; uses lsan_pkg.
//
// Usage:
//   req_* carries one message or own action per beat (valid/ready). The node applies the
//   beat to its Lamport clock and tables at the accepting edge, then scans the peer and
//   partner tables with one stamp comparator and one priority comparator, one entry a cycle.
//   rsp_* carries exactly one result beat per request beat, in order.
//   The result beat is loaded into the result register after the scan has stepped through
//   every entry of the longer table, the partner table; the node takes no new item
//   before its previous item has been loaded into the result register.
//   req_ready is high only while no item is being worked on; an item may be accepted
//   while the previous result still waits on rsp_ready.
//   When the receiver stalls, the result is held unchanged and a finished scan waits
//   until the result register is free.
//   The register port (psel/penable/pwrite, always ready) holds total_slots at 0x0 and
//   own_id at 0x4; write it only while the node is idle.
//   Reset clears the clock, the peer and offer flags, the priorities, the pairing and the own
//   request, and sets total_slots to 10 and own_id to 0; no clearing pass is needed.
`timescale 1ns / 1ps

module lamport_slot_admission_node_top (
   input  logic                               clock,
   input  logic                               reset,
   // request beats
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [lsan_pkg::KIND_W-1:0]        req_kind,
   input  logic [lsan_pkg::PEER_ID_W-1:0]     req_peer_id,
   input  logic [lsan_pkg::PART_FLD_W-1:0]    req_partner_index,
   input  logic [lsan_pkg::MSG_CLOCK_W-1:0]   req_msg_clock,
   input  logic [lsan_pkg::SLOT_W-1:0]        req_slot_count,
   // result beats
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lsan_pkg::MSG_CLOCK_W-1:0]   rsp_clock_now,
   output logic                               rsp_send_ack,
   output logic [lsan_pkg::PART_FLD_W-1:0]    rsp_best_partner,
   output logic                               rsp_best_valid,
   output logic [lsan_pkg::PART_FLD_W-1:0]    rsp_paired_partner,
   output logic                               rsp_paired_valid,
   output logic                               rsp_all_acks_in,
   output logic                               rsp_admit,
   output logic [lsan_pkg::OCC_OUT_W-1:0]     rsp_occupied_slots,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import lsan_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OUT
   } state_type;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MSG_CLOCK_W-1:0]  clock_now_ff;
   logic                    send_ack_ff;
   logic [PART_FLD_W-1:0]   best_partner_ff;
   logic                    best_valid_ff;
   logic [PART_FLD_W-1:0]   paired_partner_ff;
   logic                    paired_valid_ff;
   logic                    all_acks_ff;
   logic                    admit_ff;
   logic [OCC_OUT_W-1:0]    occupied_ff;

   logic [TOTAL_W-1:0]      total_slots_ff, total_slots_in;
   logic [OWN_ID_W-1:0]     own_id_ff, own_id_in;

   logic                    req_take;
   logic                    load;
   logic                    csr_write;
   csr_reg_type             csr_reg;
   item_type                item;
   peer_entry_type          peer_rd;
   part_entry_type          part_rd;
   node_view_type           node;
   scan_result_type         result;
   logic [PEER_IDX_W-1:0]   peer_sel;
   logic [PART_IDX_W-1:0]   part_sel;
   logic                    scan_done;

   // register port decode
   always_comb begin
      csr_reg        = csr_reg_type'(paddr[2]);
      csr_write      = psel && penable && pwrite;
      total_slots_in = total_slots_ff;
      own_id_in      = own_id_ff;
      unique case (csr_reg)
         REG_TOTAL_SLOTS: begin
            prdata = 32'(total_slots_ff);
            if (csr_write) begin
               total_slots_in = pwdata[TOTAL_W-1:0];
            end
         end
         REG_OWN_ID: begin
            prdata = 32'(own_id_ff);
            if (csr_write) begin
               own_id_in = pwdata[OWN_ID_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_slots_ff <= RESET_TOTAL_SLOTS;
         own_id_ff      <= '0;
      end else begin
         total_slots_ff <= total_slots_in;
         own_id_ff      <= own_id_in;
      end
   end

   // request beat
   assign req_ready          = state_ff == ST_IDLE;
   assign req_take           = req_valid && req_ready;
   assign item.kind          = kind_type'(req_kind);
   assign item.peer_id       = req_peer_id;
   assign item.partner_index = req_partner_index;
   assign item.msg_clock     = req_msg_clock;
   assign item.slot_count    = req_slot_count;

   lsan_state u_state (
      .clock    (clock),
      .reset    (reset),
      .apply    (req_take),
      .item     (item),
      .own_id   (own_id_ff),
      .peer_sel (peer_sel),
      .part_sel (part_sel),
      .peer_rd  (peer_rd),
      .part_rd  (part_rd),
      .node     (node)
   );

   lsan_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .start       (req_take),
      .own_id      (own_id_ff),
      .total_slots (total_slots_ff),
      .node        (node),
      .peer_rd     (peer_rd),
      .part_rd     (part_rd),
      .peer_sel    (peer_sel),
      .part_sel    (part_sel),
      .done        (scan_done),
      .result      (result)
   );

   // sequencer: scan, then wait for a free result register
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load         = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            clock_now_ff      <= MSG_CLOCK_W'(node.lamport);
            send_ack_ff       <= node.ack;
            best_valid_ff     <= result.best_valid;
            best_partner_ff   <= result.best_valid ? PART_FLD_W'(result.best_index) : '0;
            paired_valid_ff   <= node.pair_valid;
            paired_partner_ff <= node.pair_valid ? PART_FLD_W'(node.pair_index) : '0;
            all_acks_ff       <= result.all_acks_in;
            admit_ff          <= result.admit;
            occupied_ff       <= result.occupied;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_clock_now      = clock_now_ff;
   assign rsp_send_ack       = send_ack_ff;
   assign rsp_best_partner   = best_partner_ff;
   assign rsp_best_valid     = best_valid_ff;
   assign rsp_paired_partner = paired_partner_ff;
   assign rsp_paired_valid   = paired_valid_ff;
   assign rsp_all_acks_in    = all_acks_ff;
   assign rsp_admit          = admit_ff;
   assign rsp_occupied_slots = occupied_ff;

endmodule

// ===== rtl/lsan_checker.sv =====
// Port-level checker for the Lamport slot admission node, bound to the top level.
// Sees only the top-level ports; uses lsan_pkg for widths.
`timescale 1ns / 1ps

module lsan_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [lsan_pkg::MSG_CLOCK_W-1:0]   rsp_clock_now,
   input  logic [lsan_pkg::PART_FLD_W-1:0]    rsp_best_partner,
   input  logic                               rsp_best_valid,
   input  logic                               rsp_all_acks_in,
   input  logic                               rsp_admit
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_clock_now) && $stable(rsp_admit))
      else $error("result beat changed while stalled");

   // one item at a time: busy right after an accepted beat
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item still in work");

   // a new result only appears at the end of an item's work
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result beat without an item in work");

   // admission implies every acknowledgement is in
   a_admit_acks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_admit |-> rsp_all_acks_in)
      else $error("admit without all acknowledgements");

   // no pending offer means no best partner index
   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_best_valid |-> rsp_best_partner == '0)
      else $error("best partner set without a pending offer");

endmodule

bind lamport_slot_admission_node_top lsan_checker u_lsan_checker (.*);
